@@ design/ookd_pkg.sv @@
// Shared types and constants for the OOK pulse-width remote decoder.
// Holds the configuration struct, register indexes, command codes and the
// result struct that passes between the frame core and the command matcher.
package ookd_pkg;

	localparam int FRAME_BITS_DEF = 24;
	localparam int CODE_W         = 24;
	localparam int TIME_W         = 32;
	localparam int US_W           = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CMD_W          = 3;
	localparam int NUM_CMDS       = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHORT_MIN = 3'd0,
		REG_SHORT_MAX = 3'd1,
		REG_LONG_MIN  = 3'd2,
		REG_LONG_MAX  = 3'd3,
		REG_SYNC_GAP  = 3'd4
	} reg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE     = 3'd0,
		CMD_FORWARD  = 3'd1,
		CMD_BACKWARD = 3'd2,
		CMD_LEFT     = 3'd3,
		CMD_RIGHT    = 3'd4,
		CMD_CENTER   = 3'd5,
		CMD_STOP     = 3'd6
	} cmd_t;

	localparam logic [CODE_W-1:0] CMD_CODES [NUM_CMDS] = '{
		24'hC30111, 24'hC30222, 24'hC30333, 24'hC30444, 24'hC30555, 24'hC30FFF
	};

	localparam logic [US_W-1:0] RST_SHORT_MIN = 16'd180;
	localparam logic [US_W-1:0] RST_SHORT_MAX = 16'd700;
	localparam logic [US_W-1:0] RST_LONG_MIN  = 16'd700;
	localparam logic [US_W-1:0] RST_LONG_MAX  = 16'd1900;
	localparam logic [US_W-1:0] RST_SYNC_GAP  = 16'd4500;

	typedef struct packed {
		logic [US_W-1:0] short_min;
		logic [US_W-1:0] short_max;
		logic [US_W-1:0] long_min;
		logic [US_W-1:0] long_max;
		logic [US_W-1:0] sync_gap;
	} cfg_t;

	typedef struct packed {
		logic              done;
		logic [CODE_W-1:0] fwd_code;
		logic [CODE_W-1:0] mirrored_code;
	} frame_res_t;

endpackage

@@ design/ookd_frame_core.sv @@
// Edge timing state and bit assembly for the OOK pulse-width decoder.
// Computes the interval of each edge, classifies high/low pulse pairs and
// shifts decoded bits into the frame register. Uses ookd_pkg.
module ookd_frame_core
	import ookd_pkg::*;
#(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              level,
	input  logic [TIME_W-1:0] edge_time,
	input  cfg_t              cfg,
	output frame_res_t        res
);

	localparam int CNT_W = $clog2(FRAME_BITS + 1);

	logic                  seen_q;
	logic                  last_level_q;
	logic [TIME_W-1:0]     last_time_q;
	logic [US_W-1:0]       high_q;
	logic [US_W-1:0]       low_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [FRAME_BITS-1:0] shift_q;

	logic [TIME_W-1:0]     dt;
	logic                  restart;
	logic [US_W-1:0]       high_n;
	logic [US_W-1:0]       low_n;
	logic                  both_seen;
	logic                  bit0_ok;
	logic                  bit1_ok;
	logic [FRAME_BITS-1:0] shift_n;
	logic [FRAME_BITS-1:0] shift_rev;
	logic [CNT_W-1:0]      cnt_n;
	logic                  full;
	logic [TIME_W-1:0]     direct_ext;
	logic [TIME_W-1:0]     rev_ext;

	function automatic logic in_range(input logic [US_W-1:0] t, input logic [US_W-1:0] lo,
		input logic [US_W-1:0] hi);
		return (t >= lo) && (t <= hi);
	endfunction

	always_comb begin
		dt        = edge_time - last_time_q;
		restart   = dt >= {{(TIME_W-US_W){1'b0}}, cfg.sync_gap};
		high_n    = last_level_q ? dt[US_W-1:0] : high_q;
		low_n     = last_level_q ? low_q : dt[US_W-1:0];
		both_seen = (high_n != '0) && (low_n != '0);
		bit0_ok   = in_range(high_n, cfg.short_min, cfg.short_max)
			&& in_range(low_n, cfg.long_min, cfg.long_max);
		bit1_ok   = in_range(high_n, cfg.long_min, cfg.long_max)
			&& in_range(low_n, cfg.short_min, cfg.short_max);
		// Bit 0 wins when the short and long windows overlap.
		shift_n   = {shift_q[FRAME_BITS-2:0], ~bit0_ok};
		cnt_n     = cnt_q + CNT_W'(1);
		full      = cnt_n == CNT_W'(FRAME_BITS);
		for (int i = 0; i < FRAME_BITS; i++) begin
			shift_rev[i] = shift_n[FRAME_BITS-1-i];
		end
		direct_ext = TIME_W'(shift_n);
		rev_ext    = TIME_W'(shift_rev);
	end

	always_comb begin
		res.done          = seen_q && !restart && both_seen && (bit0_ok || bit1_ok) && full;
		res.fwd_code      = direct_ext[CODE_W-1:0];
		res.mirrored_code = rev_ext[CODE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_level_q <= 1'b0;
			last_time_q  <= '0;
			high_q       <= '0;
			low_q        <= '0;
			cnt_q        <= '0;
			shift_q      <= '0;
		end else if (step) begin
			seen_q       <= 1'b1;
			last_level_q <= level;
			last_time_q  <= edge_time;
			if (seen_q) begin
				if (restart) begin
					high_q  <= '0;
					low_q   <= '0;
					cnt_q   <= '0;
					shift_q <= '0;
				end else if (!both_seen) begin
					high_q <= high_n;
					low_q  <= low_n;
				end else if (!(bit0_ok || bit1_ok) || full) begin
					// A bad pair drops the frame; a full frame is reported and cleared.
					high_q  <= '0;
					low_q   <= '0;
					cnt_q   <= '0;
					shift_q <= '0;
				end else begin
					high_q  <= '0;
					low_q   <= '0;
					cnt_q   <= cnt_n;
					shift_q <= shift_n;
				end
			end
		end
	end

endmodule

@@ design/ookd_cmd_match.sv @@
// Command lookup for a completed frame of the OOK pulse-width decoder.
// Compares the code as received, then bit-reversed, against the six command
// codes in ookd_pkg.
module ookd_cmd_match
	import ookd_pkg::*;
(
	input  frame_res_t res,
	output cmd_t       cmd
);

	cmd_t direct_cmd;
	cmd_t rev_cmd;

	always_comb begin
		direct_cmd = CMD_NONE;
		rev_cmd    = CMD_NONE;
		// Walk downward so the lowest matching entry has the last word.
		for (int i = NUM_CMDS - 1; i >= 0; i--) begin
			if (res.fwd_code == CMD_CODES[i]) begin
				direct_cmd = cmd_t'(CMD_W'(i + 1));
			end
			if (res.mirrored_code == CMD_CODES[i]) begin
				rev_cmd = cmd_t'(CMD_W'(i + 1));
			end
		end
		if (!res.done) begin
			cmd = CMD_NONE;
		end else if (direct_cmd != CMD_NONE) begin
			cmd = direct_cmd;
		end else begin
			cmd = rev_cmd;
		end
	end

endmodule

@@ design/ook_pulse_width_remote_decoder_top.sv @@
// Top level of the OOK pulse-width remote decoder: handshakes, configuration
// registers, input and result registers. Uses ookd_pkg, ookd_frame_core and
// ookd_cmd_match.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, line_level, edge_time_us | in, stall out
//  out     | out_valid, out_stall, frame_done, command, frame_code | out, stall in
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in, ready out
//
// Every edge word yields exactly one result word. A word is held in the
// input register and is then decoded into the result register, so one word
// per cycle is sustained while the output does not stall.
// Reset restores the default timing limits and clears all frame state.
// A stall on the output holds the result register; the input register still
// takes one more word before in_stall rises.
module ook_pulse_width_remote_decoder_top
	import ookd_pkg::*;
#(
	parameter int FRAME_BITS = FRAME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 line_level,
	input  logic [TIME_W-1:0]    edge_time_us,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 frame_done,
	output logic [CMD_W-1:0]     command,
	output logic [CODE_W-1:0]    frame_code,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [US_W-1:0]      cfg_data
);

	cfg_t              cfg_q;
	logic              valid_s1;
	logic              level_s1;
	logic [TIME_W-1:0] time_s1;
	logic              advance;
	logic              in_accept;
	frame_res_t        res;
	cmd_t              cmd;
	logic              out_valid_q;
	logic              frame_done_q;
	logic [CMD_W-1:0]  command_q;
	logic [CODE_W-1:0] frame_code_q;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_min <= RST_SHORT_MIN;
			cfg_q.short_max <= RST_SHORT_MAX;
			cfg_q.long_min  <= RST_LONG_MIN;
			cfg_q.long_max  <= RST_LONG_MAX;
			cfg_q.sync_gap  <= RST_SYNC_GAP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SHORT_MIN: cfg_q.short_min <= cfg_data;
				REG_SHORT_MAX: cfg_q.short_max <= cfg_data;
				REG_LONG_MIN:  cfg_q.long_min  <= cfg_data;
				REG_LONG_MAX:  cfg_q.long_max  <= cfg_data;
				REG_SYNC_GAP:  cfg_q.sync_gap  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			level_s1 <= line_level;
			time_s1  <= edge_time_us;
		end
	end

	ookd_frame_core #(
		.FRAME_BITS(FRAME_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.level     (level_s1),
		.edge_time (time_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	ookd_cmd_match u_match (
		.res (res),
		.cmd (cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_done_q <= res.done;
			command_q    <= cmd;
			frame_code_q <= res.done ? res.fwd_code : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_done = frame_done_q;
	assign command    = command_q;
	assign frame_code = frame_code_q;

	// The input side only stalls when a word is waiting behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held result");

	// A decoded word always lands in the result register.
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("decoded word did not reach the output");

	// Busy results carry no command and no code.
	a_busy_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !frame_done_q) |-> (command_q == CMD_NONE && frame_code_q == '0))
		else $error("busy result carries a command or code");

	// Only defined command codes are reported.
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (command_q <= CMD_STOP))
		else $error("command code out of range");

endmodule
